### sv/fqmm_pkg.sv
// Package: constants, register indexes and float/Q16.16 helpers for the matrix multiply stream.
package fqmm_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROW_COUNT   = 2'd0,
        CFG_INNER_COUNT = 2'd1,
        CFG_COL_COUNT   = 2'd2
    } cfg_index_t;

    localparam int CFG_W    = 13;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int OUT_IDX_W = 12;

    // Biased exponent of a single word whose mantissa lands on the Q16.16 grid unshifted
    localparam logic [7:0] Q16_EXP_BASE = 8'd134;
    // Maximum left shift when the word is brought into Q16.16
    localparam logic [7:0] MAX_LSHIFT   = 8'd15;
    // Largest right shift that leaves a nonzero value
    localparam logic [7:0] MAX_RSHIFT   = 8'd23;
    // Output exponent is this plus the leading-one position
    localparam logic [7:0] OUT_EXP_BASE = 8'd111;
    localparam logic [POS_W-1:0] FRAC_TOP_POS = 5'd23;

    typedef logic [WORD_W-1:0] word_t;

    // Normalizer prep stage contents
    typedef struct packed {
        logic             sign;
        logic             zero;
        logic [POS_W-1:0] pos;
        word_t            mag;
    } norm_t;

    // Truncate an IEEE single word to Q16.16, wrapped to 32 bits
    function automatic word_t q16_from_single(input word_t w);
        logic [7:0]  expv;
        logic [7:0]  sh;
        word_t       mant;
        word_t       mag;
        expv = w[30:23];
        mant = {8'h00, 1'b1, w[22:0]};
        mag  = '0;
        if (expv >= Q16_EXP_BASE) begin
            sh  = expv - Q16_EXP_BASE;
            if (sh > MAX_LSHIFT) begin
                sh = MAX_LSHIFT;
            end
            mag = mant << sh[3:0];
        end else begin
            sh = Q16_EXP_BASE - expv;
            if (sh <= MAX_RSHIFT) begin
                mag = mant >> sh[4:0];
            end
        end
        if (w[30:0] == 31'd0) begin
            mag = '0;
        end
        return w[31] ? (word_t'(0) - mag) : mag;
    endfunction

    // Position of the highest set bit (0 when no bit is set)
    function automatic logic [POS_W-1:0] lead_pos(input word_t v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

### sv/float_q16_matmul_stream.sv
// Top level: streaming Q16.16 matrix multiply with IEEE single words in and out.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | s_valid s_ready s_a_word s_b_word             | in
//  result  | m_valid m_ready m_c_word m_row m_col          | out
//          | m_last_result                                 |
//  config  | cfg_wr_en cfg_index cfg_data                  | in
//
// One operand pair is taken every cycle while s_ready is high; the only loop is
// the accumulator add, so no bubbles are needed between pairs. A result is
// registered in turn through the q, p, r, n and m stages after the last pair of its dot product is taken.
// Reset (aresetn low at a clock edge) clears counters, accumulator, valid bits
// and sets all three counts to 1. A stalled result stage backs pressure up
// stage by stage; empty stages keep taking items while a result waits.
module float_q16_matmul_stream
    import fqmm_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_W-1:0]    s_a_word,
    input  logic [WORD_W-1:0]    s_b_word,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_W-1:0]    m_c_word,
    output logic [OUT_IDX_W-1:0] m_row,
    output logic [OUT_IDX_W-1:0] m_col,
    output logic                 m_last_result
);

    localparam int IDX_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_DIM);

    // Configuration registers
    logic [CFG_W-1:0] row_count_reg, inner_count_reg, col_count_reg;

    // Pipeline stages
    logic        x_valid_reg;
    word_t       x_a_reg, x_b_reg;
    logic        q_valid_reg;
    word_t       q_a_reg, q_b_reg;
    logic        p_valid_reg;
    logic        p_neg_reg;
    word_t       p_mag_reg;
    word_t       acc_reg, acc_next;
    logic [IDX_W-1:0] inner_idx_reg, col_idx_reg, row_idx_reg;
    logic        r_valid_reg;
    word_t       r_sum_reg;
    logic [IDX_W-1:0] r_row_reg, r_col_reg;
    logic        r_last_reg;
    logic        n_valid_reg;
    norm_t       n_reg, n_next;
    logic [IDX_W-1:0] n_row_reg, n_col_reg;
    logic        n_last_reg;
    logic        m_valid_reg;
    word_t       m_c_word_reg;
    logic [IDX_W-1:0] m_row_reg, m_col_reg;
    logic        m_last_reg;

    // Handshake chain
    logic m_free, n_ready, r_ready, acc_take, p_ready, q_ready, x_ready;

    // Effective counts and counter decisions
    logic [CMP_W-1:0] eff_rows, eff_inner, eff_cols;
    logic             inner_done, row_end, col_end;

    // Conversion and multiply
    word_t q_a_next, q_b_next;
    word_t a_abs, b_abs, prod_sum;
    logic  prod_neg;

    // Output assembly
    word_t c_next;
    word_t shifted;

    function automatic logic [CMP_W-1:0] eff_count(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] e;
        e = CMP_W'(v);
        if (v == '0) begin
            e = CMP_W'(1);
        end else if (e > MAX_CNT) begin
            e = MAX_CNT;
        end
        return e;
    endfunction

    assign eff_rows  = eff_count(row_count_reg);
    assign eff_inner = eff_count(inner_count_reg);
    assign eff_cols  = eff_count(col_count_reg);

    assign inner_done = (CMP_W'(inner_idx_reg) + CMP_W'(1)) >= eff_inner;
    assign row_end    = (CMP_W'(row_idx_reg) + CMP_W'(1)) >= eff_rows;
    assign col_end    = (CMP_W'(col_idx_reg) + CMP_W'(1)) >= eff_cols;

    // Ready chain from the result register back to the input
    assign m_free   = !m_valid_reg || m_ready;
    assign n_ready  = !n_valid_reg || m_free;
    assign r_ready  = !r_valid_reg || n_ready;
    assign acc_take = p_valid_reg && (!inner_done || r_ready);
    assign p_ready  = !p_valid_reg || acc_take;
    assign q_ready  = !q_valid_reg || p_ready;
    assign x_ready  = !x_valid_reg || q_ready;
    assign s_ready  = x_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg   <= CFG_W'(1);
            inner_count_reg <= CFG_W'(1);
            col_count_reg   <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROW_COUNT:   row_count_reg   <= cfg_data;
                CFG_INNER_COUNT: inner_count_reg <= cfg_data;
                CFG_COL_COUNT:   col_count_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the incoming item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
        end else if (x_ready) begin
            x_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (x_ready && s_valid) begin
            x_a_reg <= s_a_word;
            x_b_reg <= s_b_word;
        end
    end

    // Convert both words to Q16.16
    assign q_a_next = q16_from_single(x_a_reg);
    assign q_b_next = q16_from_single(x_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (q_ready) begin
            q_valid_reg <= x_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && x_valid_reg) begin
            q_a_reg <= q_a_next;
            q_b_reg <= q_b_next;
        end
    end

    // Sign-magnitude multiply from four 16-bit partial products
    always_comb begin
        logic [31:0] hh, hl, lh, ll;
        a_abs    = q_a_reg[31] ? (word_t'(0) - q_a_reg) : q_a_reg;
        b_abs    = q_b_reg[31] ? (word_t'(0) - q_b_reg) : q_b_reg;
        prod_neg = q_a_reg[31] ^ q_b_reg[31];
        hh       = a_abs[31:16] * b_abs[31:16];
        hl       = a_abs[31:16] * b_abs[15:0];
        lh       = a_abs[15:0]  * b_abs[31:16];
        ll       = a_abs[15:0]  * b_abs[15:0];
        prod_sum = {hh[15:0], 16'h0000} + hl + lh + {16'h0000, ll[31:16]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ready) begin
            p_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && q_valid_reg) begin
            p_mag_reg <= prod_sum;
            p_neg_reg <= prod_neg;
        end
    end

    // Accumulate and advance the i, j, k counters
    assign acc_next = p_neg_reg ? (acc_reg - p_mag_reg) : (acc_reg + p_mag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            inner_idx_reg <= '0;
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
        end else if (acc_take) begin
            if (!inner_done) begin
                acc_reg       <= acc_next;
                inner_idx_reg <= inner_idx_reg + IDX_W'(1);
            end else begin
                acc_reg       <= '0;
                inner_idx_reg <= '0;
                if (!col_end) begin
                    col_idx_reg <= col_idx_reg + IDX_W'(1);
                end else begin
                    col_idx_reg <= '0;
                    row_idx_reg <= row_end ? '0 : row_idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // Hold the finished dot product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (r_ready) begin
            r_valid_reg <= acc_take && inner_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_ready && acc_take && inner_done) begin
            r_sum_reg  <= acc_next;
            r_row_reg  <= row_idx_reg;
            r_col_reg  <= col_idx_reg;
            r_last_reg <= row_end && col_end;
        end
    end

    // Take magnitude and find the leading one
    always_comb begin
        n_next.sign = r_sum_reg[31];
        n_next.zero = (r_sum_reg == '0);
        n_next.mag  = r_sum_reg[31] ? (word_t'(0) - r_sum_reg) : r_sum_reg;
        n_next.pos  = lead_pos(n_next.mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (n_ready) begin
            n_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_ready && r_valid_reg) begin
            n_reg      <= n_next;
            n_row_reg  <= r_row_reg;
            n_col_reg  <= r_col_reg;
            n_last_reg <= r_last_reg;
        end
    end

    // Shift the leading one to bit 23 and pack the single word
    always_comb begin
        if (n_reg.pos >= FRAC_TOP_POS) begin
            shifted = n_reg.mag >> (n_reg.pos - FRAC_TOP_POS);
        end else begin
            shifted = n_reg.mag << (FRAC_TOP_POS - n_reg.pos);
        end
        if (n_reg.zero) begin
            c_next = '0;
        end else begin
            c_next = {n_reg.sign, OUT_EXP_BASE + 8'(n_reg.pos), shifted[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_free) begin
            m_valid_reg <= n_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_free && n_valid_reg) begin
            m_c_word_reg <= c_next;
            m_row_reg    <= n_row_reg;
            m_col_reg    <= n_col_reg;
            m_last_reg   <= n_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_c_word      = m_c_word_reg;
    assign m_row         = OUT_IDX_W'(m_row_reg);
    assign m_col         = OUT_IDX_W'(m_col_reg);
    assign m_last_result = m_last_reg;

endmodule
